// ===== hdl/fpsd_pkg.sv =====
// fpsd_pkg: shared types and constants of the fir power spike detector
// no dependencies
`timescale 1ns / 1ps
package fpsd_pkg;
    localparam int MAX_TAPS_DEF    = 64;
    localparam int CHANNELS_DEF    = 4;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IN_CH           = 4;
    localparam int COEF_BITS       = 16;
    localparam int FILT_BITS       = 16;
    localparam int THR_BITS        = 32;
    localparam int POS_BITS        = 32;
    localparam int PWR_BITS        = 17;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int ACC_BITS        = 48;
    localparam int SS_BITS         = 34;
    localparam int FILT_SHIFT      = 5;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_COEF   = 2'd1;
    localparam logic [1:0] CMD_THRESH = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REFRACTORY = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CH_ENABLE  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] sample_ch0;
        logic [15:0] sample_ch1;
        logic [15:0] sample_ch2;
        logic [15:0] sample_ch3;
        logic [5:0]  entry_index;
        logic [15:0] coef_value;
        logic [31:0] threshold_value;
    } req_t;

    typedef struct packed {
        logic        center_valid;
        logic        spike;
        logic [31:0] spike_position;
        logic [16:0] power_ch0;
        logic [16:0] power_ch1;
        logic [16:0] power_ch2;
        logic [16:0] power_ch3;
    } rsp_t;

    // sqrt unit handshake
    typedef struct packed {
        logic start;
    } sqrt_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_sts_t;
endpackage

// ===== hdl/fpsd_if.sv =====
// fpsd_if: valid/ready channel carrying one payload
// depends on nothing but the payload type given as parameter
`timescale 1ns / 1ps
interface fpsd_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fir_power_threshold_spike_detector_core.sv =====
// fir_power_threshold_spike_detector_core: top level of the spike detector
// depends on fpsd_pkg, fpsd_if, fpsd_sqrt
`timescale 1ns / 1ps
// usage
//   req (sink): one request per command; sample step, coefficient write or
//   threshold write. rsp (source): one result per request.
//   cfg: plain write port, index 0 tap_count, 1 refractory, 2 channel_enable,
//   to be written only while the block is idle; the block does not enforce it.
// timing
//   a write command goes from S_IDLE to S_OUT, which raises its result.
//   a sample step runs per enabled channel a tap-serial MAC over T taps
//   (one multiply-accumulate per cycle, shared multiplier), a power sum of
//   four squares and a 17-step shared square root; a disabled channel is
//   skipped with power 0, and a step before the history holds T samples
//   returns a result without a valid center.
// reset
//   history and coefficients cleared through a fill count and valid bits;
//   thresholds zeroed; registers return to tap_count 32, refractory 16, enable 15.
// stall
//   the result sits in an output register; req stays low until it is taken.
module fir_power_threshold_spike_detector_core
    import fpsd_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    fpsd_if.sink                      req,
    fpsd_if.source                    rsp,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);
    localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW  = $clog2(MAX_TAPS + 1);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HW  = AW + CW;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH, S_CH, S_MAC, S_MAC_LAST, S_FILT,
        S_SQ, S_SQRT_GO, S_SQRT_WAIT, S_DECIDE, S_OUT
    } state_t;

    // configuration
    logic [6:0]  tap_count_reg;
    logic [15:0] refractory_reg;
    logic [3:0]  ch_enable_reg;

    // memories: sample history per channel row, coefficients
    logic signed [SAMPLE_BITS-1:0] hist_mem [CHANNELS*MAX_TAPS];
    logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]           coef_vld_reg;
    logic [THR_BITS-1:0]           thr_reg [CHANNELS];
    logic signed [FILT_BITS-1:0]   fh_reg [CHANNELS][3];

    state_t state_reg;
    req_t   q_reg;
    rsp_t   out_reg;
    logic   out_vld_reg;

    logic [AW-1:0]   wr_pos_reg;
    logic [TW-1:0]   fill_reg;
    logic [POS_BITS-1:0] count_reg;
    logic [POS_BITS-1:0] last_pos_reg;
    logic            seen_reg;

    logic [CW-1:0]   ch_reg;
    logic [TW-1:0]   j_reg;
    logic [TW-1:0]   t_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [SAMPLE_BITS-1:0] h_rd_reg;
    logic signed [COEF_BITS-1:0]   c_rd_reg;
    logic            c_ok_reg;
    logic            mac_go_reg;
    logic signed [31:0] prod_reg;
    logic signed [FILT_BITS-1:0] f_reg;
    logic [1:0]      sq_reg;
    logic [SS_BITS-1:0] ss_reg;
    logic            fire_reg;
    logic [PWR_BITS-1:0] pw_reg [CHANNELS];

    // tap count clamped to [2, MAX_TAPS]
    logic [TW-1:0] taps_use;
    always_comb
    begin
        if ({25'd0, tap_count_reg} < 32'd2)
            taps_use = TW'(2);
        else if ({25'd0, tap_count_reg} > 32'(MAX_TAPS))
            taps_use = TW'(MAX_TAPS);
        else
            taps_use = TW'(tap_count_reg);
    end

    // sample read address for tap j: wr_pos - t + j
    logic [AW-1:0] rd_slot;
    logic [AW:0]   rd_tmp;
    always_comb
    begin
        rd_tmp = {1'b0, wr_pos_reg} + (AW+1)'(MAX_TAPS) - (AW+1)'(t_reg)
                 + (AW+1)'(j_reg);
        if (rd_tmp >= (AW+1)'(MAX_TAPS))
            rd_tmp = rd_tmp - (AW+1)'(MAX_TAPS);
        if (rd_tmp >= (AW+1)'(MAX_TAPS))
            rd_tmp = rd_tmp - (AW+1)'(MAX_TAPS);
        rd_slot = rd_tmp[AW-1:0];
    end

    // shared square multiplier operand
    logic signed [FILT_BITS-1:0] sq_op;
    always_comb
    begin
        case (sq_reg)
            2'd0: sq_op = f_reg;
            2'd1: sq_op = fh_reg[ch_reg][0];
            2'd2: sq_op = fh_reg[ch_reg][1];
            default: sq_op = fh_reg[ch_reg][2];
        endcase
    end

    // shift right 5 with floor, saturate
    logic signed [ACC_BITS-1:0] acc_sh;
    logic signed [FILT_BITS-1:0] f_sat;
    always_comb
    begin
        acc_sh = acc_reg >>> FILT_SHIFT;
        if (acc_sh > ACC_BITS'(32767))
            f_sat = 16'sh7fff;
        else if (acc_sh < -ACC_BITS'(32768))
            f_sat = 16'sh8000;
        else
            f_sat = acc_sh[FILT_BITS-1:0];
    end

    // sqrt unit
    sqrt_ctl_t sq_ctl;
    sqrt_sts_t sq_sts;
    logic [PWR_BITS-1:0] root;
    assign sq_ctl.start = (state_reg == S_SQRT_GO);
    fpsd_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .ctl(sq_ctl), .radicand(ss_reg),
        .sts(sq_sts), .root(root)
    );

    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] pos_gap;
    assign pos  = count_reg - POS_BITS'(t_reg) + POS_BITS'(t_reg >> 1) + 1'b1;
    assign pos_gap = pos - last_pos_reg;

    logic [SAMPLE_BITS-1:0] smp [IN_CH];
    assign smp[0] = q_reg.sample_ch0[SAMPLE_BITS-1:0];
    assign smp[1] = q_reg.sample_ch1[SAMPLE_BITS-1:0];
    assign smp[2] = q_reg.sample_ch2[SAMPLE_BITS-1:0];
    assign smp[3] = q_reg.sample_ch3[SAMPLE_BITS-1:0];

    assign req.ready = (state_reg == S_IDLE) && !out_vld_reg;
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= 7'd32;
            refractory_reg <= 16'd16;
            ch_enable_reg <= 4'd15;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAP_COUNT:  tap_count_reg <= cfg_data[6:0];
                REG_REFRACTORY: refractory_reg <= cfg_data;
                REG_CH_ENABLE:  ch_enable_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // memories: written once per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PUSH)
            hist_mem[HW'({ch_reg, wr_pos_reg})] <=
                (32'(ch_reg) < IN_CH) ? smp[ch_reg] : '0;
        h_rd_reg <= hist_mem[HW'({ch_reg, rd_slot})];
        if (state_reg == S_IDLE && req.valid && req.ready
            && req.data.command == CMD_COEF && 32'(req.data.entry_index) < MAX_TAPS)
            coef_mem[AW'(req.data.entry_index)] <= req.data.coef_value;
        c_rd_reg <= coef_mem[AW'(j_reg)];
        c_ok_reg <= coef_vld_reg[AW'(j_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_vld_reg <= 1'b0;
            out_reg <= '0;
            coef_vld_reg <= '0;
            wr_pos_reg <= '0;
            fill_reg <= '0;
            count_reg <= '0;
            last_pos_reg <= '0;
            seen_reg <= 1'b0;
            ch_reg <= '0;
            j_reg <= '0;
            t_reg <= '0;
            acc_reg <= '0;
            mac_go_reg <= 1'b0;
            prod_reg <= '0;
            f_reg <= '0;
            sq_reg <= '0;
            ss_reg <= '0;
            fire_reg <= 1'b0;
            q_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                thr_reg[c] <= '0;
                pw_reg[c] <= '0;
                for (int k = 0; k < 3; k++)
                    fh_reg[c][k] <= '0;
            end
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        q_reg <= req.data;
                        out_reg <= '0;
                        ch_reg <= '0;
                        case (req.data.command)
                            CMD_SAMPLE: state_reg <= S_PUSH;
                            CMD_COEF:
                            begin
                                if (32'(req.data.entry_index) < MAX_TAPS)
                                    coef_vld_reg[AW'(req.data.entry_index)] <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            CMD_THRESH:
                            begin
                                if (32'(req.data.entry_index) < CHANNELS)
                                    thr_reg[CW'(req.data.entry_index)] <=
                                        req.data.threshold_value;
                                state_reg <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_PUSH:
                begin
                    // one channel row written per cycle
                    if (32'(ch_reg) == CHANNELS - 1)
                    begin
                        ch_reg <= '0;
                        wr_pos_reg <= (32'(wr_pos_reg) == MAX_TAPS - 1) ? '0
                                      : wr_pos_reg + 1'b1;
                        count_reg <= count_reg + 1'b1;
                        t_reg <= taps_use;
                        fire_reg <= 1'b0;
                        if (fill_reg < TW'(MAX_TAPS))
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            if (fill_reg + 1'b1 >= taps_use)
                                state_reg <= S_CH;
                            else
                                state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_CH;
                    end
                    else
                        ch_reg <= ch_reg + 1'b1;
                end
                S_CH:
                begin
                    out_reg.center_valid <= 1'b1;
                    pw_reg[ch_reg] <= '0;
                    j_reg <= '0;
                    acc_reg <= '0;
                    mac_go_reg <= 1'b0;
                    if (ch_enable_reg[ch_reg[1:0]] && 32'(ch_reg) < 4)
                        state_reg <= S_MAC;
                    else if (32'(ch_reg) == CHANNELS - 1)
                        state_reg <= S_DECIDE;
                    else
                        ch_reg <= ch_reg + 1'b1;
                end
                S_MAC:
                begin
                    // address j issued; data of j-1 multiplied; product of j-2 summed
                    if (mac_go_reg)
                        acc_reg <= acc_reg + ACC_BITS'(prod_reg);
                    if (j_reg != '0)
                    begin
                        prod_reg <= c_ok_reg ? h_rd_reg * c_rd_reg : 32'sd0;
                        mac_go_reg <= 1'b1;
                    end
                    if (j_reg == t_reg)
                        state_reg <= S_MAC_LAST;
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_MAC_LAST:
                begin
                    acc_reg <= acc_reg + ACC_BITS'(prod_reg);
                    state_reg <= S_FILT;
                end
                S_FILT:
                begin
                    f_reg <= f_sat;
                    sq_reg <= '0;
                    ss_reg <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    ss_reg <= ss_reg + SS_BITS'($unsigned(32'(sq_op) * 32'(sq_op)));
                    sq_reg <= sq_reg + 1'b1;
                    if (sq_reg == 2'd3)
                        state_reg <= S_SQRT_GO;
                end
                S_SQRT_GO:
                begin
                    fh_reg[ch_reg][2] <= fh_reg[ch_reg][1];
                    fh_reg[ch_reg][1] <= fh_reg[ch_reg][0];
                    fh_reg[ch_reg][0] <= f_reg;
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (sq_sts.done)
                    begin
                        pw_reg[ch_reg] <= root;
                        if ({15'd0, root} > thr_reg[ch_reg])
                            fire_reg <= 1'b1;
                        if (32'(ch_reg) == CHANNELS - 1)
                            state_reg <= S_DECIDE;
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                            state_reg <= S_CH;
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (fire_reg && (!seen_reg ||
                        (!pos_gap[POS_BITS-1] && pos_gap >= {16'd0, refractory_reg})))
                    begin
                        last_pos_reg <= pos;
                        seen_reg <= 1'b1;
                        out_reg.spike <= 1'b1;
                        out_reg.spike_position <= pos;
                    end
                    out_reg.power_ch0 <= pw_reg[0];
                    out_reg.power_ch1 <= (CHANNELS > 1) ? pw_reg[CW'(1 % CHANNELS)] : '0;
                    out_reg.power_ch2 <= (CHANNELS > 2) ? pw_reg[CW'(2 % CHANNELS)] : '0;
                    out_reg.power_ch3 <= (CHANNELS > 3) ? pw_reg[CW'(3 % CHANNELS)] : '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_vld_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/fpsd_sqrt.sv =====
// fpsd_sqrt: iterative floor square root, two result bits per step pair
// depends on fpsd_pkg
`timescale 1ns / 1ps
module fpsd_sqrt
    import fpsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  sqrt_ctl_t           ctl,
    input  logic [SS_BITS-1:0]  radicand,
    output sqrt_sts_t           sts,
    output logic [PWR_BITS-1:0] root
);
    localparam int STEPS = SS_BITS / 2;
    localparam int SW    = $clog2(STEPS + 1);

    logic [SS_BITS-1:0]  x_reg, x_next;
    logic [SS_BITS-1:0]  r_reg, r_next;
    logic [SS_BITS-1:0]  bit_reg, bit_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SS_BITS-1:0]  trial;

    assign trial = r_reg + bit_reg;

    always_comb
    begin
        x_next = x_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            x_next = radicand;
            r_next = '0;
            bit_next = {2'b01, {(SS_BITS-2){1'b0}}};
            cnt_next = SW'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root = r_reg[PWR_BITS-1:0];
endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for fir_power_threshold_spike_detector_core
// depends on fpsd_pkg, fpsd_if and the core rtl
`timescale 1ns / 1ps
module testbench;
    import fpsd_pkg::*;

    localparam int NTAPS     = 64;
    localparam int NCH       = 4;
    localparam int IDLE_LIMIT = 40000;

    // behavioral copy of the detector plus the queue of expected results
    class spike_scoreboard;
        logic signed [15:0] hist[NCH][NTAPS];
        logic signed [15:0] coef[NTAPS];
        logic [31:0]        thresh[NCH];
        logic signed [15:0] filt[NCH][3];
        logic [31:0]        step_total;
        logic [31:0]        last_pos;
        bit                 seen;
        int                 fill;
        int                 wr;
        logic [6:0]         taps_reg;
        logic [15:0]        refr_reg;
        logic [3:0]         en_reg;
        rsp_t               expected_q[$];
        int                 errors;

        function new();
            foreach (hist[c, i]) hist[c][i] = '0;
            foreach (coef[i]) coef[i] = '0;
            foreach (thresh[c]) thresh[c] = '0;
            foreach (filt[c, i]) filt[c][i] = '0;
            step_total = '0;
            last_pos  = '0;
            seen      = 0;
            fill      = 0;
            wr        = 0;
            taps_reg  = 7'd32;
            refr_reg  = 16'd16;
            en_reg    = 4'hF;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
            if (idx == REG_TAP_COUNT) taps_reg = val[6:0];
            else if (idx == REG_REFRACTORY) refr_reg = val;
            else if (idx == REG_CH_ENABLE) en_reg = val[3:0];
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_request(req_t r);
            rsp_t           res;
            int             t;
            logic [31:0]    pos;
            logic [31:0]    d;
            longint         acc;
            longint         f;
            longint unsigned ss;
            logic [16:0]    pw[NCH];
            bit             fire;
            logic signed [15:0] s[NCH];
            res  = '0;
            fire = 0;
            if (r.command == CMD_COEF)
                coef[r.entry_index] = r.coef_value;
            else if (r.command == CMD_THRESH)
            begin
                if (r.entry_index < NCH) thresh[r.entry_index] = r.threshold_value;
            end
            else if (r.command == CMD_SAMPLE)
            begin
                s[0] = r.sample_ch0;
                s[1] = r.sample_ch1;
                s[2] = r.sample_ch2;
                s[3] = r.sample_ch3;
                for (int c = 0; c < NCH; c++) hist[c][wr] = s[c];
                wr = (wr + 1) % NTAPS;
                step_total = step_total + 1;
                if (fill < NTAPS) fill++;
                t = taps_reg < 2 ? 2 : (taps_reg > NTAPS ? NTAPS : taps_reg);
                if (fill >= t)
                begin
                    pos = step_total - t + t / 2 + 1;
                    for (int c = 0; c < NCH; c++)
                    begin
                        pw[c] = '0;
                        if (en_reg[c])
                        begin
                            acc = 0;
                            for (int j = 0; j < t; j++)
                                acc += longint'(hist[c][(wr + NTAPS - t + j) % NTAPS])
                                       * longint'(coef[j]);
                            // arithmetic shift is floor division by 32
                            f = acc >>> FILT_SHIFT;
                            if (f > 32767) f = 32767;
                            if (f < -32768) f = -32768;
                            ss = f * f;
                            for (int j = 0; j < 3; j++)
                                ss += longint'(filt[c][j]) * longint'(filt[c][j]);
                            filt[c][2] = filt[c][1];
                            filt[c][1] = filt[c][0];
                            filt[c][0] = f;
                            pw[c] = root(ss);
                            if (root(ss) > thresh[c]) fire = 1;
                        end
                    end
                    if (fire && seen)
                    begin
                        d = pos - last_pos;
                        if (d[31] || d < refr_reg) fire = 0;
                    end
                    res.center_valid = 1'b1;
                    if (fire)
                    begin
                        last_pos = pos;
                        seen = 1;
                        res.spike = 1'b1;
                        res.spike_position = pos;
                    end
                    res.power_ch0 = pw[0];
                    res.power_ch1 = pw[1];
                    res.power_ch2 = pw[2];
                    res.power_ch3 = pw[3];
                end
            end
            expected_q.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", 32'(got.spike_position), 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.center_valid !== want.center_valid)
                report("center_valid", got.center_valid, want.center_valid);
            if (got.spike !== want.spike) report("spike", got.spike, want.spike);
            if (got.spike_position !== want.spike_position)
                report("spike_position", got.spike_position, want.spike_position);
            if (got.power_ch0 !== want.power_ch0) report("power_ch0", got.power_ch0, want.power_ch0);
            if (got.power_ch1 !== want.power_ch1) report("power_ch1", got.power_ch1, want.power_ch1);
            if (got.power_ch2 !== want.power_ch2) report("power_ch2", got.power_ch2, want.power_ch2);
            if (got.power_ch3 !== want.power_ch3) report("power_ch3", got.power_ch3, want.power_ch3);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // no-idle window shared by sender and receiver
    bit quiet;
    int idle_cycles;
    spike_scoreboard sb;

    fpsd_if #(.payload_t(req_t)) req_ch ();
    fpsd_if #(.payload_t(rsp_t)) rsp_ch ();

    fir_power_threshold_spike_detector_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // monitor: note accepted requests, check results, drive ready, watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                idle_cycles++;
                if (rsp_ch.valid && rsp_ch.ready)
                begin
                    sb.check(rsp_ch.data);
                    idle_cycles = 0;
                end
                if (req_ch.valid && req_ch.ready)
                begin
                    sb.note_request(req_ch.data);
                    idle_cycles = 0;
                end
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("watchdog expired");
                    $display("fir_power_threshold_spike_detector_core test failed");
                    $finish;
                end
            end
            rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    // one request, held until accepted, then an occasional gap
    task push(req_t r);
        req_ch.data  <= r;
        req_ch.valid <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        if (!quiet && $urandom_range(0, 99) < 8)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task push_sample(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
        req_t r;
        r            = req_t'({$urandom, $urandom, $urandom});
        r.command    = CMD_SAMPLE;
        r.sample_ch0 = a;
        r.sample_ch1 = b;
        r.sample_ch2 = c;
        r.sample_ch3 = d;
        push(r);
    endtask

    task push_write(logic [1:0] cmd, logic [5:0] idx, logic [31:0] val);
        req_t r;
        r                 = req_t'({$urandom, $urandom, $urandom});
        r.command         = cmd;
        r.entry_index     = idx;
        r.coef_value      = val[15:0];
        r.threshold_value = val;
        push(r);
    endtask

    // stop the sender and wait until every result has come back
    task drain;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // register write, only while the block is idle
    task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    function logic [15:0] rand_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'h8000;
        if (k == 1) return 16'h7FFF;
        if (k < 5) return 16'($signed($urandom_range(0, 4000)) - 2000);
        return 16'($urandom);
    endfunction

    // mostly sample steps with random content, some table writes and junk
    task random_item(int thr_mode);
        int k;
        logic [31:0] thr;
        k = $urandom_range(0, 99);
        if (k < 72)
            push_sample(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        else if (k < 86)
            push_write(CMD_COEF, 6'($urandom), 32'($urandom));
        else if (k < 96)
        begin
            case (thr_mode)
                0: thr = $urandom_range(0, 3000);
                1: thr = $urandom_range(0, 70000);
                default: thr = $urandom;
            endcase
            push_write(CMD_THRESH, 6'($urandom_range(0, 7)), thr);
        end
        else
            push_write(CMD_UNUSED, 6'($urandom), $urandom);
    endtask

    initial
    begin
        logic [6:0]  taps_set[6];
        logic [15:0] refr_set[6];
        logic [3:0]  en_set[6];
        int          n;
        sb           = new();
        quiet        = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table extremes, ignored entries, unused command
        push_write(CMD_COEF, 6'd0, 32'h0000_7FFF);
        push_write(CMD_COEF, 6'd63, 32'h0000_8000);
        push_write(CMD_COEF, 6'd16, 32'h0000_2000);
        push_write(CMD_COEF, 6'd1, 32'h0000_E000);
        push_write(CMD_THRESH, 6'd0, 32'd0);
        push_write(CMD_THRESH, 6'd3, 32'hFFFF_FFFF);
        push_write(CMD_THRESH, 6'd7, 32'd5);
        push_write(CMD_THRESH, 6'd63, 32'd1);
        push_write(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);
        // tap count 0 clamps to two taps; only the first sample leaves no valid center
        drain;
        write_reg(REG_TAP_COUNT, 16'd0);
        push_sample(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        push_sample(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
        push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_write(CMD_COEF, 6'd1, 32'h0000_8000);
        push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);

        // settings per phase, extremes included; tap 127 clamps to max
        taps_set = '{7'd2, 7'd127, 7'd1, 7'd64, 7'd8, 7'($urandom_range(2, 40))};
        refr_set = '{16'd1, 16'd65535, 16'd3, 16'd40, 16'd0, 16'($urandom_range(1, 30))};
        en_set   = '{4'hF, 4'h5, 4'h0, 4'hA, 4'h3, 4'($urandom)};
        for (int p = 0; p < 6; p++)
        begin
            // sender holds off until all results have come back
            drain;
            write_reg(REG_TAP_COUNT, 16'(taps_set[p]));
            write_reg(REG_REFRACTORY, refr_set[p]);
            write_reg(REG_CH_ENABLE, 16'(en_set[p]));
            n = (taps_set[p] >= 64 || taps_set[p] == 7'd127) ? 70 : 95;
            for (int i = 0; i < n; i++)
            begin
                // in phase 3, a long stretch without gaps on either side
                quiet = (p == 3);
                random_item(p % 3);
            end
            quiet = 0;
        end

        drain;
        repeat (500) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("fir_power_threshold_spike_detector_core test passed");
        else
            $display("fir_power_threshold_spike_detector_core test failed");
        $finish;
    end
endmodule

// ===== fir_power_threshold_spike_detector_core.f =====
hdl/fpsd_pkg.sv
hdl/fpsd_if.sv
hdl/fpsd_sqrt.sv
hdl/fir_power_threshold_spike_detector_core.sv
tb/testbench.sv
